// File: hdl/dlsh_pkg.sv
// Shared types, sizes and codes for the depth-limited shape hit test.
`timescale 1ns / 1ps

package dlsh_pkg;

    localparam int MAX_SHAPES  = 16;
    localparam int COORD_WIDTH = 20;
    localparam int IDX_W       = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;
    localparam int CNT_W       = $clog2(MAX_SHAPES + 1);
    localparam int RAD_W       = COORD_WIDTH - 1;
    localparam int RAD_SQ_W    = 2 * RAD_W;
    localparam int DIFF_SQ_W   = 2 * COORD_WIDTH + 1;
    localparam int DIST_SQ_W   = DIFF_SQ_W + 1;
    localparam int DEPTH_W     = 16;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] KIND_POINT   = 2'd0;
    localparam logic [1:0] KIND_SEGMENT = 2'd1;
    localparam logic [1:0] KIND_RECT    = 2'd2;
    localparam logic [1:0] KIND_CIRCLE  = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_LIMIT_ON = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_DEPTH     = CFG_IDX_W'(1);

    typedef struct packed {
        logic [1:0]                    cmd;
        logic [1:0]                    shape_kind;
        logic signed [COORD_WIDTH-1:0] first_x;
        logic signed [COORD_WIDTH-1:0] first_y;
        logic signed [COORD_WIDTH-1:0] second_x;
        logic signed [COORD_WIDTH-1:0] second_y;
        logic [RAD_W-1:0]              radius;
        logic [DEPTH_W-1:0]            shape_depth;
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
    } in_item_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] status;
    } out_item_t;

    // One stored shape, corners already normalized.
    typedef struct packed {
        logic [1:0]                    kind;
        logic signed [COORD_WIDTH-1:0] lo_x;
        logic signed [COORD_WIDTH-1:0] lo_y;
        logic signed [COORD_WIDTH-1:0] hi_x;
        logic signed [COORD_WIDTH-1:0] hi_y;
        logic [RAD_SQ_W-1:0]           rad_sq;
        logic [DEPTH_W-1:0]            depth;
    } shape_t;

    // Query transaction moving from one cell to the next.
    typedef struct packed {
        logic                          vld;
        logic                          hit;
        logic signed [COORD_WIDTH-1:0] px;
        logic signed [COORD_WIDTH-1:0] py;
    } link_t;

    typedef struct packed {
        logic               limit_on;
        logic [DEPTH_W-1:0] draw_depth;
    } cfg_t;

endpackage

// File: hdl/dlsh_cell.sv
// One chain cell: holds a shape and tests the passing query point against it.
`timescale 1ns / 1ps

module dlsh_cell import dlsh_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   wr_en,
    input  shape_t wr_shape,
    input  logic   in_use,
    input  cfg_t   cfg,
    input  link_t  link_in,
    output link_t  link_out
);

    shape_t                  shape_reg;
    link_t                   link_reg;
    link_t                   link_next;
    logic [DIFF_SQ_W-1:0]    sqx_reg, sqx_next;
    logic [DIFF_SQ_W-1:0]    sqy_reg, sqy_next;
    logic                    rect_reg, rect_next;

    logic signed [COORD_WIDTH:0]     dx, dy;
    logic signed [DIST_SQ_W-1:0]     dx_sq, dy_sq;
    logic [DIST_SQ_W-1:0]            dist_sq;
    logic                            circle_in;
    logic                            contains;
    logic                            eligible;

    // First half: squared offsets and box test on the incoming point.
    always_comb begin
        dx        = {link_in.px[COORD_WIDTH-1], link_in.px}
                  - {shape_reg.lo_x[COORD_WIDTH-1], shape_reg.lo_x};
        dy        = {link_in.py[COORD_WIDTH-1], link_in.py}
                  - {shape_reg.lo_y[COORD_WIDTH-1], shape_reg.lo_y};
        dx_sq     = dx * dx;
        dy_sq     = dy * dy;
        sqx_next  = dx_sq[DIFF_SQ_W-1:0];
        sqy_next  = dy_sq[DIFF_SQ_W-1:0];
        rect_next = (link_in.px >= shape_reg.lo_x) && (link_in.px <= shape_reg.hi_x) &&
                    (link_in.py >= shape_reg.lo_y) && (link_in.py <= shape_reg.hi_y);
        link_next = link_in;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            shape_reg <= wr_shape;
        end
        sqx_reg  <= sqx_next;
        sqy_reg  <= sqy_next;
        rect_reg <= rect_next;
        if (!aresetn) begin
            link_reg <= '0;
        end else begin
            link_reg <= link_next;
        end
    end

    // Second half: finish the circle test and fold this shape into the hit.
    always_comb begin
        dist_sq   = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        circle_in = dist_sq <= DIST_SQ_W'(shape_reg.rad_sq);
        contains  = (shape_reg.kind == KIND_CIRCLE) ? circle_in : rect_reg;
        eligible  = in_use && (!cfg.limit_on || (shape_reg.depth <= cfg.draw_depth));
        link_out     = link_reg;
        link_out.hit = link_reg.hit | (link_reg.vld & eligible & contains);
    end

endmodule

// File: hdl/depth_limited_shape_hit_test.sv
// Top level of the depth-limited shape hit test: command decode, shape table control, cell chain.
`timescale 1ns / 1ps

// Usage:
//   s_valid/s_ready/s_data carry command transactions (add shape, clear table, query point).
//   m_valid/m_ready/m_data return exactly one result (hit, status) per command.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write depth_limit_on (index 0) and draw_depth
//   (index 1); cfg_ready is always high, other indexes are ignored. Write only while idle.
// Latency and throughput:
//   Add, clear and unused commands resolve in the accept cycle; the result is registered
//   into m_valid/m_data (or the hold register while m_ready is low), and the next command
//   can be taken once it is, so these run at one per cycle while the receiver keeps up.
//   A query walks the chain of MAX_SHAPES cells, one cell per cycle (each cell holds one
//   shape and registers its squared offsets); its result then passes into the output
//   register, and no new command is taken until the query has left the chain.
//   The chain length sets how long a query takes; one command is in flight at a time.
// Reset (aresetn low, synchronous): the table is emptied, both registers return to zero,
//   the chain and the output valid flag are cleared. No clearing pass is needed.
// Stall: while m_ready is low the finished result waits in the output register and the
//   block may take one more command; that command's result waits in a hold register.

module depth_limited_shape_hit_test import dlsh_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    state_t          state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    cfg_t            cfg_reg, cfg_next;
    logic            m_valid_reg, m_valid_next;
    out_item_t       m_data_reg, m_data_next;
    out_item_t       pend_reg, pend_next;

    logic            accept;
    logic            shape_ok;
    logic [1:0]      add_status;
    logic            wr_go;
    shape_t          new_shape;
    logic            res_valid;
    out_item_t       res_data;
    logic            out_free;
    logic [RAD_SQ_W-1:0] rad_sq;

    link_t           chain [MAX_SHAPES:0];
    logic [MAX_SHAPES-1:0] in_use;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Validate the shape and normalize its corners.
    always_comb begin
        case (s_data.shape_kind)
            KIND_SEGMENT: shape_ok = (s_data.first_x == s_data.second_x)
                                   != (s_data.first_y == s_data.second_y);
            KIND_RECT:    shape_ok = (s_data.first_x != s_data.second_x)
                                   && (s_data.first_y != s_data.second_y);
            KIND_CIRCLE:  shape_ok = (s_data.radius != '0);
            default:      shape_ok = 1'b1;
        endcase

        if (count_reg >= CNT_W'(MAX_SHAPES)) begin
            add_status = STATUS_FULL;
        end else if (!shape_ok) begin
            add_status = STATUS_INVALID;
        end else begin
            add_status = STATUS_OK;
        end

        rad_sq           = s_data.radius * s_data.radius;
        new_shape.kind   = s_data.shape_kind;
        new_shape.rad_sq = rad_sq;
        new_shape.depth  = s_data.shape_depth;
        if ((s_data.shape_kind == KIND_POINT) || (s_data.shape_kind == KIND_CIRCLE)) begin
            new_shape.lo_x = s_data.first_x;
            new_shape.lo_y = s_data.first_y;
            new_shape.hi_x = s_data.first_x;
            new_shape.hi_y = s_data.first_y;
        end else begin
            new_shape.lo_x = (s_data.first_x < s_data.second_x) ? s_data.first_x
                                                                 : s_data.second_x;
            new_shape.lo_y = (s_data.first_y < s_data.second_y) ? s_data.first_y
                                                                 : s_data.second_y;
            new_shape.hi_x = (s_data.first_x < s_data.second_x) ? s_data.second_x
                                                                 : s_data.first_x;
            new_shape.hi_y = (s_data.first_y < s_data.second_y) ? s_data.second_y
                                                                 : s_data.first_y;
        end

        wr_go = accept && (s_data.cmd == CMD_ADD) && (add_status == STATUS_OK);
    end

    // Inject a query at the head of the chain in its accept cycle.
    always_comb begin
        chain[0].vld = accept && (s_data.cmd == CMD_QUERY);
        chain[0].hit = 1'b0;
        chain[0].px  = s_data.point_x;
        chain[0].py  = s_data.point_y;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_SHAPES; gi++) begin : g_cell
            // Entries at or above the fill count take no part in a query.
            assign in_use[gi] = (CNT_W'(gi) < count_reg);

            dlsh_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .wr_en    (wr_go && (count_reg[IDX_W-1:0] == IDX_W'(gi))),
                .wr_shape (new_shape),
                .in_use   (in_use[gi]),
                .cfg      (cfg_reg),
                .link_in  (chain[gi]),
                .link_out (chain[gi+1])
            );
        end
    endgenerate

    // Pick the result that is ready this cycle and route it to the output or hold it.
    always_comb begin
        res_valid = 1'b0;
        res_data  = '0;
        case (state_reg)
            ST_IDLE: begin
                res_valid       = accept && (s_data.cmd != CMD_QUERY);
                res_data.status = (s_data.cmd == CMD_ADD) ? add_status : STATUS_OK;
            end
            ST_RUN: begin
                res_valid    = chain[MAX_SHAPES].vld;
                res_data.hit = chain[MAX_SHAPES].hit;
            end
            ST_HOLD: begin
                res_valid = 1'b1;
                res_data  = pend_reg;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase

        out_free     = !m_valid_reg || m_ready;
        state_next   = state_reg;
        pend_next    = pend_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;

        if (accept && (s_data.cmd == CMD_QUERY)) begin
            state_next = ST_RUN;
        end else if (res_valid) begin
            if (out_free) begin
                m_valid_next = 1'b1;
                m_data_next  = res_data;
                state_next   = ST_IDLE;
            end else begin
                pend_next  = res_data;
                state_next = ST_HOLD;
            end
        end

        count_next = count_reg;
        if (accept && (s_data.cmd == CMD_CLEAR)) begin
            count_next = '0;
        end else if (wr_go) begin
            count_next = count_reg + CNT_W'(1);
        end

        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_DEPTH_LIMIT_ON) begin
                cfg_next.limit_on = cfg_data[0];
            end else if (cfg_index == CFG_DRAW_DEPTH) begin
                cfg_next.draw_depth = cfg_data[DEPTH_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg   <= pend_next;
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            cfg_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef SYNTHESIS
    // A query leaves the chain only while the control waits for it.
    a_chain_end_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        chain[MAX_SHAPES].vld |-> (state_reg == ST_RUN))
        else $error("query result left the chain outside the run state");

    // The fill count never passes the table size.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_SHAPES))
        else $error("shape count exceeds table size");

    // An accepted query starts the chain walk and blocks new commands.
    a_query_starts_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_data.cmd == CMD_QUERY)) |=> (state_reg == ST_RUN) && !s_ready)
        else $error("query accepted without entering run state");

    // A table write grows the count by exactly one.
    a_write_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_go |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("shape write did not advance the count");
`endif

endmodule
